/* design/etmm_pkg.sv */
// Package for the Euler translate/rotate/scale model matrix block.
// Holds widths, CORDIC constants, arctangent table and the request struct.
package etmm_pkg;

   localparam int TrigIterations = 16;
   localparam int TableLen = 24;
   localparam int CordicSteps = (TrigIterations < TableLen) ? TrigIterations : TableLen;

   localparam logic signed [17:0] FullTurn    = 18'sd46080;
   localparam logic signed [17:0] HalfTurn    = 18'sd23040;
   localparam logic signed [17:0] QuarterTurn = 18'sd11520;
   localparam logic signed [34:0] CordicGain  = 35'sd652032874;
   localparam logic signed [20:0] SatLimit    = 21'sd655360;
   localparam logic signed [20:0] OneQ16      = 21'sd65536;

   typedef struct packed {
      logic signed [16:0] move_x;
      logic signed [16:0] move_y;
      logic signed [16:0] move_z;
      logic signed [16:0] angle_x;
      logic signed [16:0] angle_y;
      logic signed [16:0] angle_z;
      logic [15:0]        stretch_x;
      logic [15:0]        stretch_y;
      logic [15:0]        stretch_z;
   } req_type;

   // Reduced angle with a flip flag, as the front classifies it.
   typedef struct packed {
      logic signed [14:0] ang;
      logic               flip;
   } red_type;

   typedef struct packed {
      red_type            rx;
      red_type            ry;
      red_type            rz;
      logic signed [20:0] tx;
      logic signed [20:0] ty;
      logic signed [20:0] tz;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic [15:0]        sz;
   } job_type;

   function automatic logic signed [26:0] atan_q16(input logic [4:0] i);
      logic signed [26:0] v;
      case (i)
         5'd0: v = 27'sd2949120;  5'd1: v = 27'sd1740967;
         5'd2: v = 27'sd919879;   5'd3: v = 27'sd466945;
         5'd4: v = 27'sd234379;   5'd5: v = 27'sd117304;
         5'd6: v = 27'sd58666;    5'd7: v = 27'sd29335;
         5'd8: v = 27'sd14668;    5'd9: v = 27'sd7334;
         5'd10: v = 27'sd3667;    5'd11: v = 27'sd1833;
         5'd12: v = 27'sd917;     5'd13: v = 27'sd458;
         5'd14: v = 27'sd229;     5'd15: v = 27'sd115;
         5'd16: v = 27'sd57;      5'd17: v = 27'sd29;
         5'd18: v = 27'sd14;      5'd19: v = 27'sd7;
         5'd20: v = 27'sd4;       5'd21: v = 27'sd2;
         5'd22: v = 27'sd1;       default: v = 27'sd0;
      endcase
      return v;
   endfunction

   // Wrap to [-180,180) then fold into [-90,90] with a flip flag.
   function automatic red_type reduce(input logic signed [16:0] a);
      logic signed [17:0] r;
      red_type o;
      r = 18'(a);
      if (r >= HalfTurn) r = r - FullTurn;
      if (r >= HalfTurn) r = r - FullTurn;
      if (r < -HalfTurn) r = r + FullTurn;
      if (r < -HalfTurn) r = r + FullTurn;
      o.flip = 1'b0;
      if (r > QuarterTurn) begin
         r = r - HalfTurn;
         o.flip = 1'b1;
      end else if (r < -QuarterTurn) begin
         r = r + HalfTurn;
         o.flip = 1'b1;
      end
      o.ang = r[14:0];
      return o;
   endfunction

   // Q16 product with rounding.
   function automatic logic signed [17:0] mulq(input logic signed [17:0] a,
                                               input logic signed [17:0] b);
      logic signed [35:0] p;
      p = a * b + 36'sd32768;
      return 18'(p >>> 16);
   endfunction

   function automatic logic signed [20:0] sat(input logic signed [35:0] v);
      logic signed [20:0] o;
      if (v > 36'(SatLimit)) o = SatLimit;
      else if (v < -36'(SatLimit)) o = -SatLimit;
      else o = v[20:0];
      return o;
   endfunction

endpackage

/* design/euler_trs_model_matrix.sv */
// Top level of the model matrix builder; depends on etmm_pkg and its submodules.
// A request passes the front queue, CORDIC, AB and R stages, emitter matrix and
// output register before its first row is offered; the other three rows follow
// one per cycle while rsp_ready holds; these rows on one output set the rate.
// Synchronous active-high reset empties the queue and pipeline; data is not reset.
module euler_trs_model_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [16:0] req_move_x,
   input  logic signed [16:0] req_move_y,
   input  logic signed [16:0] req_move_z,
   input  logic signed [16:0] req_angle_x,
   input  logic signed [16:0] req_angle_y,
   input  logic signed [16:0] req_angle_z,
   input  logic [15:0]        req_stretch_x,
   input  logic [15:0]        req_stretch_y,
   input  logic [15:0]        req_stretch_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_number,
   output logic signed [20:0] rsp_col0,
   output logic signed [20:0] rsp_col1,
   output logic signed [20:0] rsp_col2,
   output logic signed [20:0] rsp_col3,
   output logic               rsp_last_row
);
   etmm_pkg::req_type req;
   etmm_pkg::job_type job;
   logic q_valid, q_ready;

   assign req = '{req_move_x, req_move_y, req_move_z, req_angle_x, req_angle_y,
                  req_angle_z, req_stretch_x, req_stretch_y, req_stretch_z};

   etmm_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_req(req), .q_valid(q_valid), .q_ready(q_ready), .q_job(job)
   );

   etmm_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_job(job), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_number(rsp_row_number), .rsp_col0(rsp_col0), .rsp_col1(rsp_col1),
      .rsp_col2(rsp_col2), .rsp_col3(rsp_col3), .rsp_last_row(rsp_last_row)
   );
endmodule

/* design/etmm_front.sv */
// Front part: takes requests, reduces the angles and forms translations.
// Depends on etmm_pkg; feeds a two-entry queue toward the back part.
module etmm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  etmm_pkg::req_type   in_req,
   output logic                q_valid,
   input  logic                q_ready,
   output etmm_pkg::job_type   q_job
);
   etmm_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   etmm_pkg::job_type job;
   logic push, pop;

   always_comb begin
      job.rx = etmm_pkg::reduce(in_req.angle_x);
      job.ry = etmm_pkg::reduce(in_req.angle_y);
      job.rz = etmm_pkg::reduce(in_req.angle_z);
      job.tx = etmm_pkg::sat(36'(in_req.move_x) <<< 4);
      job.ty = etmm_pkg::sat(36'(in_req.move_y) <<< 4);
      job.tz = etmm_pkg::sat(36'(in_req.move_z) <<< 4);
      job.sx = in_req.stretch_x;
      job.sy = in_req.stretch_y;
      job.sz = in_req.stretch_z;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_job = mem_ff[rp_ff];
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= job;
   end
endmodule

/* design/etmm_cordic.sv */
// Three-lane CORDIC pipeline: one stage per iteration, one angle per lane.
// Depends on etmm_pkg; gives rounded Q16 sine and cosine.
module etmm_cordic (
   input  logic                     clock,
   input  logic                     advance,
   input  etmm_pkg::red_type        ang [3],
   output logic signed [17:0]       sin_q [3],
   output logic signed [17:0]       cos_q [3]
);
   localparam int N = etmm_pkg::CordicSteps;
   logic signed [34:0] x_ff [1:N][3];
   logic signed [34:0] y_ff [1:N][3];
   logic signed [26:0] z_ff [1:N][3];
   logic               f_ff [1:N][3];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic signed [34:0] x_cur [3];
      logic signed [34:0] y_cur [3];
      logic signed [26:0] z_cur [3];
      logic               f_cur [3];

      // The first stage starts from the gain on the x axis.
      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               x_cur[l] = etmm_pkg::CordicGain;
               y_cur[l] = 35'sd0;
               z_cur[l] = 27'(ang[l].ang) <<< 9;
               f_cur[l] = ang[l].flip;
            end
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               x_cur[l] = x_ff[s][l];
               y_cur[l] = y_ff[s][l];
               z_cur[l] = z_ff[s][l];
               f_cur[l] = f_ff[s][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            for (int l = 0; l < 3; l++) begin
               if (z_cur[l] >= 0) begin
                  x_ff[s+1][l] <= x_cur[l] - (y_cur[l] >>> s);
                  y_ff[s+1][l] <= y_cur[l] + (x_cur[l] >>> s);
                  z_ff[s+1][l] <= z_cur[l] - etmm_pkg::atan_q16(5'(s));
               end else begin
                  x_ff[s+1][l] <= x_cur[l] + (y_cur[l] >>> s);
                  y_ff[s+1][l] <= y_cur[l] - (x_cur[l] >>> s);
                  z_ff[s+1][l] <= z_cur[l] + etmm_pkg::atan_q16(5'(s));
               end
               f_ff[s+1][l] <= f_cur[l];
            end
         end
      end
   end

   always_comb begin
      logic signed [34:0] xr, yr;
      for (int l = 0; l < 3; l++) begin
         xr = (x_ff[N][l] + 35'sd8192) >>> 14;
         yr = (y_ff[N][l] + 35'sd8192) >>> 14;
         cos_q[l] = f_ff[N][l] ? -xr[17:0] : xr[17:0];
         sin_q[l] = f_ff[N][l] ? -yr[17:0] : yr[17:0];
      end
   end
endmodule

/* design/etmm_back.sv */
// Back part: CORDIC, matrix products, scaling and row output.
// Depends on etmm_pkg and etmm_cordic. A stalling pipeline with output register.
module etmm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  etmm_pkg::job_type   q_job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_row_number,
   output logic signed [20:0]  rsp_col0,
   output logic signed [20:0]  rsp_col1,
   output logic signed [20:0]  rsp_col2,
   output logic signed [20:0]  rsp_col3,
   output logic                rsp_last_row
);
   localparam int N = etmm_pkg::CordicSteps;
   localparam int D = N + 2;   // cordic stages, AB stage, R stage

   // The emitter walks four rows of the finished item; the pipeline
   // advances when the emitter takes a new one or when its last stage is empty.
   logic [D-1:0] v_ff, v_in;
   etmm_pkg::job_type j_ff [D];
   logic advance, take;
   etmm_pkg::red_type angs [3];
   logic signed [17:0] sn [3], cs [3];
   logic signed [17:0] ab_ff [3][3];
   logic signed [17:0] rot_ff [3][3];
   logic busy_ff, busy_in;
   logic [1:0] row_ff, row_in;
   logic signed [20:0] m_ff [3][4];
   logic ovalid_ff;
   logic signed [20:0] oc_ff [4];
   logic [1:0] orow_ff;

   assign angs[0] = q_job.rx;
   assign angs[1] = q_job.ry;
   assign angs[2] = q_job.rz;

   // A slot frees when the emitter is idle or on its final row being taken.
   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;
   assign take = v_ff[D-1] && (!busy_ff || (row_ff == 2'd3 && out_free));
   assign advance = !v_ff[D-1] || take;
   assign q_ready = advance;
   assign v_in = {v_ff[D-2:0], q_valid};

   etmm_cordic u_cordic (
      .clock(clock), .advance(advance), .ang(angs), .sin_q(sn), .cos_q(cs)
   );

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= v_in;
      if (advance) begin
         j_ff[0] <= q_job;
         for (int k = 1; k < D; k++) j_ff[k] <= j_ff[k-1];
         ab_ff[0][0] <= cs[1];
         ab_ff[0][1] <= 18'sd0;
         ab_ff[0][2] <= -sn[1];
         ab_ff[1][0] <= etmm_pkg::mulq(sn[0], sn[1]);
         ab_ff[1][1] <= cs[0];
         ab_ff[1][2] <= etmm_pkg::mulq(sn[0], cs[1]);
         ab_ff[2][0] <= etmm_pkg::mulq(cs[0], sn[1]);
         ab_ff[2][1] <= -sn[0];
         ab_ff[2][2] <= etmm_pkg::mulq(cs[0], cs[1]);
      end
   end

   // Z-rotation values ride with the AB stage.
   logic signed [17:0] sz_ff, cz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         sz_ff <= sn[2];
         cz_ff <= cs[2];
         for (int r = 0; r < 3; r++) begin
            rot_ff[r][0] <= etmm_pkg::mulq(ab_ff[r][0], cz_ff)
                            - etmm_pkg::mulq(ab_ff[r][1], sz_ff);
            rot_ff[r][1] <= etmm_pkg::mulq(ab_ff[r][0], sz_ff)
                            + etmm_pkg::mulq(ab_ff[r][1], cz_ff);
            rot_ff[r][2] <= ab_ff[r][2];
         end
      end
   end

   // Scaling happens as the emitter captures the item.
   function automatic logic signed [20:0] scale(input logic signed [17:0] v,
                                                input logic [15:0] s);
      logic signed [35:0] p;
      p = 36'(v) * $signed({1'b0, s}) + 36'sd2048;
      return etmm_pkg::sat(p >>> 12);
   endfunction

   assign busy_in = take ? 1'b1 :
                    (busy_ff && row_ff == 2'd3 && out_free) ? 1'b0 : busy_ff;
   always_comb begin
      row_in = row_ff;
      if (take) row_in = 2'd0;
      else if (busy_ff && out_free) row_in = row_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         row_ff <= row_in;
         if (out_free) ovalid_ff <= busy_ff;
      end
      if (take) begin
         for (int r = 0; r < 3; r++) begin
            m_ff[r][0] <= scale(rot_ff[r][0], j_ff[D-1].sx);
            m_ff[r][1] <= scale(rot_ff[r][1], j_ff[D-1].sy);
            m_ff[r][2] <= scale(rot_ff[r][2], j_ff[D-1].sz);
         end
         m_ff[0][3] <= j_ff[D-1].tx;
         m_ff[1][3] <= j_ff[D-1].ty;
         m_ff[2][3] <= j_ff[D-1].tz;
      end
      if (out_free && busy_ff) begin
         orow_ff <= row_ff;
         for (int c = 0; c < 4; c++)
            oc_ff[c] <= (row_ff == 2'd3) ? ((c == 3) ? etmm_pkg::OneQ16 : 21'sd0)
                                         : m_ff[row_ff][c];
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_row_number = orow_ff;
   assign rsp_col0 = oc_ff[0];
   assign rsp_col1 = oc_ff[1];
   assign rsp_col2 = oc_ff[2];
   assign rsp_col3 = oc_ff[3];
   assign rsp_last_row = (orow_ff == 2'd3);
endmodule

/* design/etmm_checker.sv */
// Port-level checks for the model matrix builder.
// Depends on euler_trs_model_matrix ports only; bound to the top level.
module etmm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_row_number,
   input logic signed [20:0] rsp_col3,
   input logic               rsp_last_row
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == (rsp_row_number == 2'd3)))
      else $error("last flag does not match row 3");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |-> rsp_col3 == 21'sd65536)
      else $error("row 3 column 3 is not one");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=>
         rsp_valid && rsp_row_number == $past(rsp_row_number) + 2'd1)
      else $error("rows out of order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_number))
      else $error("stalled response changed");
endmodule

bind euler_trs_model_matrix etmm_checker u_etmm_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_row_number(rsp_row_number), .rsp_col3(rsp_col3),
   .rsp_last_row(rsp_last_row)
);
